// ----- hw/rtl/breakpoint_linear_interpolator_assert.svh -----
// Assertion macros for the breakpoint interpolator checker
`ifndef BREAKPOINT_LINEAR_INTERPOLATOR_ASSERT_SVH
`define BREAKPOINT_LINEAR_INTERPOLATOR_ASSERT_SVH
`define BLI_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define BLI_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// ----- hw/rtl/bli_pkg.sv -----
`timescale 1ns / 1ps
package bli_pkg;
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;
    localparam int   POS_W     = 32;
    localparam int   CNT_W     = 11;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic search_init;
        logic probe_rd;
        logic probe_upd;
        logic pair_rd0;
        logic pair_rd1;
        logic pair_cap;
        logic div_init;
        logic div_step;
        logic finish;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic search_done;
        logic early_out;
        logic div_done;
    } t_sts;
endpackage

// ----- hw/rtl/bli_if.sv -----
`timescale 1ns / 1ps
interface bli_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [10:0] point_index;
    logic [31:0] point_position;
    logic [31:0] point_value;
    logic [31:0] query_position;
    modport source (output valid, cmd, point_index, point_position, point_value,
                    query_position, input ready);
    modport sink (input valid, cmd, point_index, point_position, point_value,
                  query_position, output ready);
endinterface

interface bli_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] interpolated_value;
    logic        beyond_table;
    modport source (output valid, interpolated_value, beyond_table, input ready);
    modport sink (input valid, interpolated_value, beyond_table, output ready);
endinterface

// ----- hw/rtl/breakpoint_linear_interpolator.sv -----
`timescale 1ns / 1ps
// Breakpoint linear interpolator.
// i_in (sink): one request per item. cmd load writes breakpoint point_index
// (1..MAX_POINTS) and gives no result. cmd query searches the
// table for the first breakpoint at or above query_position and interpolates
// between it and the one below (origin at 0/0 is implicit).
// o_out (source): interpolated_value and beyond_table, one per query, held in
// an output register until ready.
// A query runs its search probes through the single registered table read
// port, ceil(log2(point_count+2)) probes, at most 11, then sees the search
// end, fetches the pair and decides, runs the 64-step radix-2 division of
// the 64-bit product and hands over. Exact hits and out-of-table queries
// skip the divide. Loads are taken back to back.
// One item is in work at a time; i_in.ready is high only when idle, so the
// next request is taken the cycle after a query's result is handed over.
// Reset (synchronous, active low) clears control and sets point_count to 1;
// table contents stay undefined until loaded.
// If the receiver stalls, one result waits in the output register and the
// next finished query waits in the done state, holding i_in.ready low.
module breakpoint_linear_interpolator #(
    parameter int MAX_POINTS  = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [10:0] i_cfg_wdata,
    bli_in_if.sink      i_in,
    bli_out_if.source   o_out
);
    import bli_pkg::*;

    t_cmd        cmd;
    t_sts        sts;
    logic [10:0] r_count;

    // configuration register for point_count; the user writes it only while idle, the block does not enforce this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_count <= 11'd1;
        else if (i_cfg_we) r_count <= i_cfg_wdata;
    end

    bli_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_cmd   (i_in.cmd),
        .o_in_ready (i_in.ready),
        .i_out_busy (o_out.valid && !o_out.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bli_dp #(.MAX_POINTS(MAX_POINTS), .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_cfg_count      (r_count),
        .i_cmd_bit        (i_in.cmd),
        .i_point_index    (i_in.point_index),
        .i_point_position (i_in.point_position),
        .i_point_value    (i_in.point_value),
        .i_query_position (i_in.query_position),
        .o_res_valid      (o_out.valid),
        .i_res_ready      (o_out.ready),
        .o_res_value      (o_out.interpolated_value),
        .o_res_beyond     (o_out.beyond_table)
    );
endmodule

// ----- hw/rtl/bli_ctrl.sv -----
`timescale 1ns / 1ps
module bli_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_cmd,
    output logic          o_in_ready,
    input  logic          i_out_busy,
    input  bli_pkg::t_sts i_sts,
    output bli_pkg::t_cmd o_cmd
);
    import bli_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PRD  = 3'd1;
    localparam logic [2:0] S_PUPD = 3'd2;
    localparam logic [2:0] S_RD0  = 3'd3;
    localparam logic [2:0] S_RD1  = 3'd4;
    localparam logic [2:0] S_CAP  = 3'd5;
    localparam logic [2:0] S_DIV  = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [2:0] r_state, n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    if (i_in_cmd == CMD_QUERY) begin
                        o_cmd.search_init = 1'b1;
                        n_state = S_PRD;
                    end
                end
            end
            S_PRD: begin
                if (i_sts.search_done) n_state = S_RD0;
                else begin
                    o_cmd.probe_rd = 1'b1;
                    n_state = S_PUPD;
                end
            end
            S_PUPD: begin
                o_cmd.probe_upd = 1'b1;
                n_state = S_PRD;
            end
            S_RD0: begin
                o_cmd.pair_rd0 = 1'b1;
                n_state = S_RD1;
            end
            S_RD1: begin
                o_cmd.pair_rd1 = 1'b1;
                n_state = S_CAP;
            end
            S_CAP: begin
                o_cmd.pair_cap = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (i_sts.early_out) n_state = S_DONE;
                else if (i_sts.div_done) n_state = S_DONE;
                else o_cmd.div_step = 1'b1;
            end
            S_DONE: begin
                if (!i_out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        o_cmd.div_init = (r_state == S_CAP);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end
endmodule

// ----- hw/rtl/bli_dp.sv -----
`timescale 1ns / 1ps
module bli_dp #(
    parameter int MAX_POINTS  = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  bli_pkg::t_cmd i_cmd,
    output bli_pkg::t_sts o_sts,
    input  logic [10:0]   i_cfg_count,
    input  logic          i_cmd_bit,
    input  logic [10:0]   i_point_index,
    input  logic [31:0]   i_point_position,
    input  logic [31:0]   i_point_value,
    input  logic [31:0]   i_query_position,
    output logic          o_res_valid,
    input  logic          i_res_ready,
    output logic [31:0]   o_res_value,
    output logic          o_res_beyond
);
    import bli_pkg::*;

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int IW = $clog2(MAX_POINTS + 2);
    localparam int PW = 2 * POS_W;

    logic [POS_W-1:0]       r_pos_mem [MAX_POINTS];
    logic [VALUE_WIDTH-1:0] r_val_mem [MAX_POINTS];
    logic [POS_W-1:0]       r_rd_pos;
    logic [VALUE_WIDTH-1:0] r_rd_val;

    logic [IW-1:0]    r_lo, r_hi, r_mid, r_count;
    logic [POS_W-1:0] r_x;
    logic             r_mid_zero;
    logic [IW-1:0]    n_rd_idx;
    logic             rd_en;
    logic [POS_W-1:0] r_p0;
    logic [VALUE_WIDTH-1:0] r_v0;
    logic             r_early, r_beyond, r_neg;
    logic [PW-1:0]    r_rem;
    logic [PW-1:0]    r_quo;
    logic [POS_W-1:0] r_dp;
    logic [6:0]       r_step;
    logic             r_valid;
    logic [31:0]      r_res;
    logic [31:0]      r_out_value;
    logic             r_out_beyond;
    logic             r_rz0;

    // load write and single registered read port
    wire wr_ok = i_cmd.capture && (i_cmd_bit == CMD_LOAD) && (i_point_index != 11'd0)
                 && ({21'd0, i_point_index} <= 32'(MAX_POINTS));
    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_pos_mem[AW'(i_point_index - 11'd1)] <= i_point_position;
            r_val_mem[AW'(i_point_index - 11'd1)] <= i_point_value[VALUE_WIDTH-1:0];
        end
        if (rd_en) begin
            r_rd_pos <= r_pos_mem[AW'(n_rd_idx - IW'(1))];
            r_rd_val <= r_val_mem[AW'(n_rd_idx - IW'(1))];
        end
    end

    always_comb begin
        rd_en    = i_cmd.probe_rd || i_cmd.pair_rd0 || i_cmd.pair_rd1;
        n_rd_idx = r_lo + ((r_hi - r_lo) >> 1);
        if (i_cmd.pair_rd0) n_rd_idx = r_lo - IW'(1);
        if (i_cmd.pair_rd1) n_rd_idx = r_lo;
    end

    wire [POS_W-1:0] probe_pos = r_mid_zero ? '0 : r_rd_pos;
    wire [VALUE_WIDTH-1:0] rd_v = r_mid_zero ? '0 : r_rd_val;

    // pair capture: p1/v1 arrive in S_CAP, p0/v0 were latched in S_RD1
    wire [POS_W-1:0] dx = r_x - r_p0;
    wire [POS_W-1:0] dp = probe_pos - r_p0;
    wire [VALUE_WIDTH-1:0] dv = (rd_v >= r_v0) ? rd_v - r_v0 : r_v0 - rd_v;

    always_ff @(posedge i_clk) begin
        if (i_cmd.search_init) begin
            r_x     <= i_query_position;
            r_lo    <= '0;
            r_count <= ({21'd0, i_cfg_count} > 32'(MAX_POINTS)) ? IW'(MAX_POINTS)
                                                               : IW'(i_cfg_count);
            r_hi    <= (({21'd0, i_cfg_count} > 32'(MAX_POINTS)) ? IW'(MAX_POINTS)
                                                                 : IW'(i_cfg_count)) + IW'(1);
        end
        if (rd_en) begin
            r_mid      <= n_rd_idx;
            r_mid_zero <= (n_rd_idx == '0) || (n_rd_idx > IW'(MAX_POINTS));
        end
        if (i_cmd.probe_upd) begin
            if (probe_pos < r_x) r_lo <= r_mid + IW'(1);
            else r_hi <= r_mid;
        end
        r_rz0 <= i_cmd.pair_rd0;
        if (r_rz0 && i_cmd.pair_rd1) begin
            r_p0 <= probe_pos;
            r_v0 <= rd_v;
        end
        if (i_cmd.pair_cap) begin
            r_beyond <= 1'b0;
            r_early  <= 1'b0;
            if (r_lo > r_count) begin
                r_beyond <= 1'b1; r_early <= 1'b1; r_res <= '0;
            end else if (probe_pos == r_x) begin
                r_early <= 1'b1; r_res <= 32'(rd_v);
            end else if (probe_pos < r_x || r_lo == '0) begin
                r_beyond <= 1'b1; r_early <= 1'b1; r_res <= '0;
            end
            r_neg <= (rd_v < r_v0);
            r_dp  <= dp;
        end
        // product goes straight into the dividend shift register
        if (i_cmd.div_init) begin
            r_rem  <= '0;
            r_quo  <= PW'(dx) * PW'(dv);
            r_step <= '0;
        end
        if (i_cmd.div_step) begin
            logic [PW:0] t;
            t = {r_rem, r_quo[PW-1]} - {1'b0, {POS_W{1'b0}}, r_dp};
            if (!t[PW]) begin
                r_rem <= t[PW-1:0];
                r_quo <= {r_quo[PW-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[PW-2:0], r_quo[PW-1]};
                r_quo <= {r_quo[PW-2:0], 1'b0};
            end
            r_step <= r_step + 7'd1;
        end
        if (o_sts.div_done && !r_early && !i_cmd.div_init) begin
            if (!r_neg) r_res <= 32'(r_v0 + VALUE_WIDTH'(r_quo));
            else r_res <= 32'(r_v0 - VALUE_WIDTH'(r_quo + PW'(r_rem != '0)));
        end
    end

    // result register, loaded on finish and held until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= 1'b0;
        else if (i_cmd.finish) r_valid <= 1'b1;
        else if (i_res_ready) r_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_value  <= r_res;
            r_out_beyond <= r_beyond;
        end
    end

    assign o_sts.search_done = !(r_lo < r_hi);
    assign o_sts.early_out   = r_early;
    assign o_sts.div_done    = (r_step == 7'(PW));
    assign o_res_valid  = r_valid;
    assign o_res_value  = r_out_value;
    assign o_res_beyond = r_out_beyond;
endmodule

// ----- hw/rtl/bli_checker.sv -----
`timescale 1ns / 1ps
`include "breakpoint_linear_interpolator_assert.svh"
module bli_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic        i_cmd,
    input logic        o_valid,
    input logic        o_ready,
    input logic        o_beyond,
    input logic [31:0] o_value
);
    import bli_pkg::*;

    `BLI_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && !o_ready, o_valid)
    `BLI_ASSERT_NXT(a_out_stable, i_clk, i_rst_n, o_valid && !o_ready, $stable(o_value))
    `BLI_ASSERT_IMP(a_beyond_zero, i_clk, i_rst_n, o_valid && o_beyond, o_value == 32'd0)
    `BLI_ASSERT_NXT(a_busy_after, i_clk, i_rst_n, i_valid && i_ready && i_cmd == CMD_QUERY, !i_ready)
endmodule

bind breakpoint_linear_interpolator bli_checker u_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (i_in.valid),
    .i_ready  (i_in.ready),
    .i_cmd    (i_in.cmd),
    .o_valid  (o_out.valid),
    .o_ready  (o_out.ready),
    .o_beyond (o_out.beyond_table),
    .o_value  (o_out.interpolated_value)
);
